// ===== hdl/bced_pkg.sv =====
`timescale 1ns / 1ps
// Package for the button click event detector: item types, op and event codes,
// configuration register indexes, reset values and the tracking state type.
// No dependencies.
package bced_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_EDGE = 2'd1,
        OP_POLL = 2'd2,
        OP_READ = 2'd3
    } op_t;

    // event codes of a result item
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PIN      = 2'd3;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RESET     = 16'd30;
    localparam logic [15:0] LONG_PRESS_RESET   = 16'd1500;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;
    localparam logic [15:0] KEY_PIN_RESET      = 16'd1;

    // pending event flag bits
    localparam int FLAG_SHORT_BIT  = 0;
    localparam int FLAG_LONG_BIT   = 1;
    localparam int FLAG_DOUBLE_BIT = 2;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [15:0] pin_id;
        logic        key_down;
    } in_item_t;

    typedef struct packed {
        event_t event_res;
        logic   pressed;
    } out_item_t;

    typedef struct packed {
        logic [15:0] debounce_interval;
        logic [15:0] long_press_time;
        logic [15:0] double_click_window;
        logic [15:0] key_pin_id;
    } cfg_t;

    typedef struct packed {
        logic        pressed_state;
        logic        long_done;
        logic        click_pending;
        logic [2:0]  pending_flags;
        logic [31:0] last_edge_time;
        logic [31:0] press_time;
        logic [31:0] release_time;
        logic [31:0] first_click_time;
    } key_state_t;

endpackage

// ===== hdl/bced_step.sv =====
`timescale 1ns / 1ps
// Single-item update of the button tracking state: next state and result item.
// Depends on bced_pkg.
module bced_step (
    input  bced_pkg::in_item_t   item,
    input  bced_pkg::cfg_t       cfg,
    input  bced_pkg::key_state_t st,
    output bced_pkg::key_state_t st_next,
    output bced_pkg::out_item_t  res
);
    import bced_pkg::*;

    logic [31:0] since_edge;
    logic [31:0] since_first;
    logic [31:0] since_press;
    logic [31:0] since_release;

    // wrapping time differences
    assign since_edge    = item.now_ms - st.last_edge_time;
    assign since_first   = item.now_ms - st.first_click_time;
    assign since_press   = item.now_ms - st.press_time;
    assign since_release = item.now_ms - st.release_time;

    // state update and event selection
    always_comb
    begin
        logic   click_tmp;
        event_t ev;
        st_next   = st;
        ev        = EV_NONE;
        click_tmp = st.click_pending;
        case (item.op)
            OP_INIT:
            begin
                st_next.pressed_state    = item.key_down;
                st_next.long_done        = 1'b0;
                st_next.click_pending    = 1'b0;
                st_next.pending_flags    = 3'b000;
                st_next.last_edge_time   = item.now_ms;
                st_next.press_time       = item.now_ms;
                st_next.release_time     = item.now_ms;
                st_next.first_click_time = item.now_ms;
            end
            OP_EDGE:
            begin
                // only debounced edges of the key pin count
                if (item.pin_id == cfg.key_pin_id
                    && since_edge >= {16'd0, cfg.debounce_interval})
                begin
                    st_next.last_edge_time = item.now_ms;
                    if (item.key_down != st.pressed_state)
                    begin
                        st_next.pressed_state = item.key_down;
                        if (item.key_down)
                        begin
                            st_next.press_time = item.now_ms;
                            st_next.long_done  = 1'b0;
                        end
                        else
                        begin
                            st_next.release_time = item.now_ms;
                            if (st.long_done)
                            begin
                                st_next.click_pending = 1'b0;
                            end
                            else if (st.click_pending
                                     && since_first <= {16'd0, cfg.double_click_window})
                            begin
                                st_next.pending_flags[FLAG_DOUBLE_BIT] = 1'b1;
                                st_next.click_pending = 1'b0;
                            end
                            else
                            begin
                                // first click, or a late second one restarting the window
                                st_next.click_pending    = 1'b1;
                                st_next.first_click_time = item.now_ms;
                            end
                        end
                    end
                end
            end
            OP_POLL:
            begin
                // long press check comes first and may cancel the click
                if (st.pressed_state && !st.long_done
                    && since_press >= {16'd0, cfg.long_press_time})
                begin
                    st_next.pending_flags[FLAG_LONG_BIT] = 1'b1;
                    st_next.long_done = 1'b1;
                    click_tmp = 1'b0;
                end
                if (click_tmp && since_release >= {16'd0, cfg.double_click_window})
                begin
                    st_next.pending_flags[FLAG_SHORT_BIT] = 1'b1;
                    click_tmp = 1'b0;
                end
                st_next.click_pending = click_tmp;
            end
            OP_READ:
            begin
                if (st.pending_flags[FLAG_DOUBLE_BIT])
                begin
                    ev = EV_DOUBLE;
                    st_next.pending_flags[FLAG_DOUBLE_BIT] = 1'b0;
                end
                else if (st.pending_flags[FLAG_LONG_BIT])
                begin
                    ev = EV_LONG;
                    st_next.pending_flags[FLAG_LONG_BIT] = 1'b0;
                end
                else if (st.pending_flags[FLAG_SHORT_BIT])
                begin
                    ev = EV_SHORT;
                    st_next.pending_flags[FLAG_SHORT_BIT] = 1'b0;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
        res.event_res = ev;
        res.pressed   = st_next.pressed_state;
    end

endmodule

// ===== hdl/button_click_event_detector_core.sv =====
`timescale 1ns / 1ps
// Button click event detector, top level: input register, config registers,
// tracking state and result register. Depends on bced_pkg and bced_step.
//
// Usage:
//   input channel in_valid / in_stall / in_item carries ops init, edge, poll and
//   read with a millisecond timestamp, a pin id and the sampled key level.
//   output channel out_valid / out_stall / out_item returns one item for every
//   input item: the event code (nonzero only for read) and the pressed state.
//   config port cfg_we / cfg_index / cfg_data writes debounce interval, long
//   press time, double click window and key pin id; write only while idle.
// Path: an accepted item is held in the input register; its state update is
//   written into the result register, which drives out_item.
// Throughput: one item per cycle while out_stall is low; the state update is one
//   pass of compares on 32-bit time differences, from input to result register.
// Reset: tracking state and pending events clear, config registers return to
//   30 / 1500 / 300 / 1; both pipeline stages empty.
// Stall: a held result keeps the input register full, then in_stall rises;
//   nothing is dropped and the state only moves when a result register slot frees.
module button_click_event_detector_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bced_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bced_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [bced_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bced_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bced_pkg::*;

    cfg_t       cfg_reg;
    key_state_t state_reg;
    key_state_t state_next;
    in_item_t   item_reg;
    logic       item_valid_reg;
    out_item_t  res_reg;
    out_item_t  res_next;
    logic       res_valid_reg;
    logic       res_free;
    logic       fire;
    logic       in_accept;

    // handshake
    assign res_free  = !res_valid_reg || !out_stall;
    assign fire      = item_valid_reg && res_free;
    assign in_stall  = item_valid_reg && !res_free;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_interval   <= DEBOUNCE_RESET;
            cfg_reg.long_press_time     <= LONG_PRESS_RESET;
            cfg_reg.double_click_window <= DOUBLE_CLICK_RESET;
            cfg_reg.key_pin_id          <= KEY_PIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:     cfg_reg.debounce_interval   <= cfg_data;
                CFG_LONG_PRESS:   cfg_reg.long_press_time     <= cfg_data;
                CFG_DOUBLE_CLICK: cfg_reg.double_click_window <= cfg_data;
                CFG_KEY_PIN:      cfg_reg.key_pin_id          <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_item;
        end
    end

    // per-item update
    bced_step u_step (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
